// File: hdl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes of the I2C master transfer sequencer: word layouts,
// phase encoding, mode codes and the action and completion codes.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int ADDR_W   = 8;
    localparam int SLEN_W   = 7;
    localparam int RLEN_W   = 16;
    localparam int LIDX_W   = 6;
    localparam int BYTE_W   = 8;
    localparam int FLAGS_W  = 7;
    localparam int ACT_W    = 2;
    localparam int CNT_W    = 2;

    // event flag bit positions
    localparam int FL_SB    = 0;
    localparam int FL_ADDR  = 1;
    localparam int FL_ADD10 = 2;
    localparam int FL_RXNE  = 3;
    localparam int FL_BTF   = 4;
    localparam int FL_TXE   = 5;
    localparam int FL_STOPF = 6;

    // control bit actions
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ON   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_OFF  = 2'd2;

    // completion codes
    localparam logic [1:0] CMP_NONE = 2'd0;
    localparam logic [1:0] CMP_OK   = 2'd1;
    localparam logic [1:0] CMP_ERR  = 2'd2;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_EVENT = 2'd2,
        MODE_ERROR = 2'd3
    } t_mode;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_START   = 6'b000010,
        PH_ADDRESS = 6'b000100,
        PH_DATA    = 6'b001000,
        PH_RESTART = 6'b010000,
        PH_RECEIVE = 6'b100000
    } t_phase;

    typedef struct packed {
        t_mode               mode;
        logic [ADDR_W-1:0]   target_address;
        logic [SLEN_W-1:0]   send_length;
        logic [RLEN_W-1:0]   receive_length;
        logic [LIDX_W-1:0]   load_index;
        logic [BYTE_W-1:0]   load_byte;
        logic [FLAGS_W-1:0]  event_flags;
        logic [BYTE_W-1:0]   rx_data;
        logic [BYTE_W-1:0]   rx_data_next;
    } t_item;

    typedef struct packed {
        logic                data_write_valid;
        logic [BYTE_W-1:0]   data_write_value;
        logic                request_start;
        logic                request_stop;
        logic [ACT_W-1:0]    ack_action;
        logic [ACT_W-1:0]    pos_action;
        logic [ACT_W-1:0]    buffer_irq_action;
        logic [CNT_W-1:0]    received_count;
        logic [RLEN_W-1:0]   received_index;
        logic [BYTE_W-1:0]   received_first;
        logic [BYTE_W-1:0]   received_second;
        logic [1:0]          completion;
    } t_result;

    typedef struct packed {
        logic                en;
        logic [LIDX_W-1:0]   index;
        logic [BYTE_W-1:0]   data;
    } t_store_wr;

endpackage

// File: hdl/i2cms_tx_store.sv
// ----------------------------------------------------------------------------
// i2cms_tx_store
// Transmit byte memory: one write port for load words, one registered read
// port that follows the send pointer, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module i2cms_tx_store
    import i2cms_pkg::*;
#(
    parameter int TX_DEPTH = 64
) (
    input  logic               i_clk,
    input  t_store_wr          i_wr,
    input  logic [SLEN_W-1:0]  i_rd_ptr,
    output logic [BYTE_W-1:0]  o_rd_data
);

    localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    logic [BYTE_W-1:0] r_mem [TX_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;
    logic [31:0]       wr_ptr;
    logic [31:0]       rd_ptr;
    logic              wr_hit;

    assign wr_ptr = 32'(i_wr.index);
    assign rd_ptr = 32'(i_rd_ptr);
    assign wr_hit = i_wr.en && (wr_ptr < 32'(TX_DEPTH));

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[wr_ptr[AW-1:0]] <= i_wr.data;
        end
        if (wr_hit && (wr_ptr == rd_ptr)) begin
            r_rd_data <= i_wr.data;
        end else if (rd_ptr < 32'(TX_DEPTH)) begin
            r_rd_data <= r_mem[rd_ptr[AW-1:0]];
        end else begin
            r_rd_data <= '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/i2cms_step.sv
// ----------------------------------------------------------------------------
// i2cms_step
// Transfer state and the one-step decision logic: start, event and error words
// update the phase and counters, load words write the transmit store, and each word forms one result word.
// ----------------------------------------------------------------------------
module i2cms_step
    import i2cms_pkg::*;
#(
    parameter int TX_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_item              i_item,
    input  logic [BYTE_W-1:0]  i_tx_byte,
    output t_store_wr          o_wr,
    output logic [SLEN_W-1:0]  o_rd_ptr,
    output t_result            o_res
);

    t_phase              r_phase,         n_phase;
    logic [ADDR_W-1:0]   r_address_byte,  n_address_byte;
    logic [SLEN_W-1:0]   r_send_total,    n_send_total;
    logic [SLEN_W-1:0]   r_send_done,     n_send_done;
    logic [RLEN_W-1:0]   r_receive_total, n_receive_total;
    logic [RLEN_W-1:0]   r_receive_done,  n_receive_done;

    t_phase              ph;
    logic [ADDR_W-1:0]   ad;
    logic [SLEN_W-1:0]   st;
    logic [SLEN_W-1:0]   sd;
    logic [RLEN_W-1:0]   rt;
    logic [RLEN_W-1:0]   rd;
    logic [RLEN_W-1:0]   rem;
    logic [FLAGS_W-1:0]  fl;
    logic                ended;
    t_result             res;

    always_comb begin
        ph    = r_phase;
        ad    = r_address_byte;
        st    = r_send_total;
        sd    = r_send_done;
        rt    = r_receive_total;
        rd    = r_receive_done;
        rem   = '0;
        fl    = i_item.event_flags;
        ended = 1'b0;
        res   = '0;
        case (i_item.mode)
            MODE_START: begin
                ad = i_item.target_address;
                if (32'(i_item.send_length) > 32'(TX_DEPTH)) begin
                    st = SLEN_W'(TX_DEPTH);
                end else begin
                    st = i_item.send_length;
                end
                sd = '0;
                rt = i_item.receive_length;
                rd = '0;
                ph = PH_START;
                res.pos_action    = ACT_OFF;
                res.ack_action    = ACT_ON;
                res.request_start = 1'b1;
            end
            MODE_LOAD: begin
            end
            MODE_EVENT: begin
                if (fl[FL_SB]) begin
                    res.data_write_valid = 1'b1;
                    if (st == '0) begin
                        res.data_write_value = ad | 8'h01;
                        if (rt == 16'd2) begin
                            res.pos_action = ACT_ON;
                        end
                    end else begin
                        res.data_write_value = ad;
                    end
                    res.buffer_irq_action = ACT_OFF;
                    res.ack_action        = ACT_ON;
                    ph = PH_ADDRESS;
                end
                if (fl[FL_ADDR] && ph == PH_ADDRESS) begin
                    ended = 1'b1;
                    if (st != '0) begin
                        if (sd < st) begin
                            res.data_write_valid = 1'b1;
                            res.data_write_value = i_tx_byte;
                            sd = sd + SLEN_W'(1);
                        end
                        if (sd >= st) begin
                            if (rt == '0) begin
                                res.request_stop = 1'b1;
                                res.completion   = CMP_OK;
                                ph = PH_IDLE;
                            end else begin
                                res.request_start = 1'b1;
                                ph = PH_RESTART;
                            end
                            st = '0;
                            sd = '0;
                        end else begin
                            ph = PH_DATA;
                        end
                    end else begin
                        if (rt == 16'd1) begin
                            res.ack_action        = ACT_OFF;
                            res.request_stop      = 1'b1;
                            res.buffer_irq_action = ACT_ON;
                        end else if (rt == 16'd2) begin
                            res.ack_action = ACT_OFF;
                        end
                        ph = PH_RECEIVE;
                    end
                end
                if (!ended && fl[FL_ADD10]) begin
                    ended = 1'b1;
                    res.request_stop = 1'b1;
                    if (ph != PH_IDLE) begin
                        res.completion = CMP_ERR;
                        ph = PH_IDLE;
                    end
                end
                if (!ended && fl[FL_RXNE] && ph == PH_RECEIVE) begin
                    if (rd >= rt) begin
                        res.request_stop = 1'b1;
                        res.completion   = CMP_ERR;
                        ph = PH_IDLE;
                    end else begin
                        rem = rt - rd;
                        if (rem >= 16'd4) begin
                            if (fl[FL_BTF]) begin
                                res.received_count = 2'd1;
                                res.received_index = rd;
                                res.received_first = i_item.rx_data;
                                rd = rd + 16'd1;
                            end
                        end else if (rem == 16'd3) begin
                            if (fl[FL_BTF]) begin
                                res.ack_action     = ACT_OFF;
                                res.received_count = 2'd1;
                                res.received_index = rd;
                                res.received_first = i_item.rx_data;
                                rd = rd + 16'd1;
                            end
                        end else if (rem == 16'd2) begin
                            if (fl[FL_BTF]) begin
                                res.request_stop    = 1'b1;
                                res.received_count  = 2'd2;
                                res.received_index  = rd;
                                res.received_first  = i_item.rx_data;
                                res.received_second = i_item.rx_data_next;
                                rt = '0;
                                rd = '0;
                                res.completion = CMP_OK;
                                ph = PH_IDLE;
                            end
                        end else begin
                            res.received_count = 2'd1;
                            res.received_index = rd;
                            res.received_first = i_item.rx_data;
                            rt = '0;
                            rd = '0;
                            res.completion = CMP_OK;
                            ph = PH_IDLE;
                        end
                    end
                end
                if (!ended && fl[FL_TXE] && ph == PH_DATA) begin
                    if (sd >= st) begin
                        if (rt == '0) begin
                            res.request_stop = 1'b1;
                            if (res.completion == CMP_NONE) begin
                                res.completion = CMP_OK;
                            end
                            ph = PH_IDLE;
                        end else begin
                            res.request_start = 1'b1;
                            ph = PH_RESTART;
                        end
                        st = '0;
                        sd = '0;
                    end else begin
                        res.data_write_valid = 1'b1;
                        res.data_write_value = i_tx_byte;
                        sd = sd + SLEN_W'(1);
                    end
                end
                if (!ended && fl[FL_STOPF]) begin
                    res.request_stop = 1'b1;
                    if (ph != PH_IDLE) begin
                        if (res.completion == CMP_NONE) begin
                            res.completion = CMP_ERR;
                        end
                        ph = PH_IDLE;
                    end
                end
            end
            MODE_ERROR: begin
                res.request_stop = 1'b1;
                if (ph != PH_IDLE) begin
                    res.completion = CMP_ERR;
                    ph = PH_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (i_adv) begin
            n_phase         = ph;
            n_address_byte  = ad;
            n_send_total    = st;
            n_send_done     = sd;
            n_receive_total = rt;
            n_receive_done  = rd;
        end else begin
            n_phase         = r_phase;
            n_address_byte  = r_address_byte;
            n_send_total    = r_send_total;
            n_send_done     = r_send_done;
            n_receive_total = r_receive_total;
            n_receive_done  = r_receive_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_address_byte  <= '0;
            r_send_total    <= '0;
            r_send_done     <= '0;
            r_receive_total <= '0;
            r_receive_done  <= '0;
        end else begin
            r_phase         <= n_phase;
            r_address_byte  <= n_address_byte;
            r_send_total    <= n_send_total;
            r_send_done     <= n_send_done;
            r_receive_total <= n_receive_total;
            r_receive_done  <= n_receive_done;
        end
    end

    assign o_wr.en    = i_adv && (i_item.mode == MODE_LOAD);
    assign o_wr.index = i_item.load_index;
    assign o_wr.data  = i_item.load_byte;
    assign o_rd_ptr   = n_send_done;
    assign o_res      = res;

`ifndef SYNTHESIS
    a_send_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_send_done <= r_send_total) && (32'(r_send_total) <= 32'(TX_DEPTH)))
        else $error("send count beyond total");

    a_recv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_receive_done <= r_receive_total)
        else $error("receive count beyond total");

    a_err_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && res.completion == CMP_ERR) |-> res.request_stop)
        else $error("error completion without stop");
`endif

endmodule

// File: hdl/i2c_master_transfer_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_unit
// I2C master write-then-read sequencer: input register, decision step with
// transmit store, and output register.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while i_out_ready does not hold the output, limited by the single decision step
// the store read port is addressed with the next send pointer, so the next byte to send is registered ahead of use
// reset: synchronous, clears phase, counters and valid flags
// reset leaves the transmit store contents untouched
module i2c_master_transfer_sequencer_unit
    import i2cms_pkg::*;
#(
    parameter int TX_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_mode,
    input  logic [ADDR_W-1:0]   i_target_address,
    input  logic [SLEN_W-1:0]   i_send_length,
    input  logic [RLEN_W-1:0]   i_receive_length,
    input  logic [LIDX_W-1:0]   i_load_index,
    input  logic [BYTE_W-1:0]   i_load_byte,
    input  logic [FLAGS_W-1:0]  i_event_flags,
    input  logic [BYTE_W-1:0]   i_rx_data,
    input  logic [BYTE_W-1:0]   i_rx_data_next,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_data_write_valid,
    output logic [BYTE_W-1:0]   o_data_write_value,
    output logic                o_request_start,
    output logic                o_request_stop,
    output logic [ACT_W-1:0]    o_ack_action,
    output logic [ACT_W-1:0]    o_pos_action,
    output logic [ACT_W-1:0]    o_buffer_irq_action,
    output logic [CNT_W-1:0]    o_received_count,
    output logic [RLEN_W-1:0]   o_received_index,
    output logic [BYTE_W-1:0]   o_received_first,
    output logic [BYTE_W-1:0]   o_received_second,
    output logic [1:0]          o_completion
);

    logic        r_in_valid, n_in_valid;
    logic        r_out_valid, n_out_valid;
    t_item       r_item;
    t_result     r_res;
    t_item       in_item;
    t_result     step_res;
    t_store_wr   st_wr;
    logic [SLEN_W-1:0] rd_ptr;
    logic [BYTE_W-1:0] tx_byte;
    logic        adv;

    assign in_item.mode           = t_mode'(i_mode);
    assign in_item.target_address = i_target_address;
    assign in_item.send_length    = i_send_length;
    assign in_item.receive_length = i_receive_length;
    assign in_item.load_index     = i_load_index;
    assign in_item.load_byte      = i_load_byte;
    assign in_item.event_flags    = i_event_flags;
    assign in_item.rx_data        = i_rx_data;
    assign in_item.rx_data_next   = i_rx_data_next;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= in_item;
        end
        if (adv) begin
            r_res <= step_res;
        end
    end

    i2cms_step #(
        .TX_DEPTH (TX_DEPTH)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_item    (r_item),
        .i_tx_byte (tx_byte),
        .o_wr      (st_wr),
        .o_rd_ptr  (rd_ptr),
        .o_res     (step_res)
    );

    i2cms_tx_store #(
        .TX_DEPTH (TX_DEPTH)
    ) u_tx_store (
        .i_clk     (i_clk),
        .i_wr      (st_wr),
        .i_rd_ptr  (rd_ptr),
        .o_rd_data (tx_byte)
    );

    assign o_out_valid         = r_out_valid;
    assign o_data_write_valid  = r_res.data_write_valid;
    assign o_data_write_value  = r_res.data_write_value;
    assign o_request_start     = r_res.request_start;
    assign o_request_stop      = r_res.request_stop;
    assign o_ack_action        = r_res.ack_action;
    assign o_pos_action        = r_res.pos_action;
    assign o_buffer_irq_action = r_res.buffer_irq_action;
    assign o_received_count    = r_res.received_count;
    assign o_received_index    = r_res.received_index;
    assign o_received_first    = r_res.received_first;
    assign o_received_second   = r_res.received_second;
    assign o_completion        = r_res.completion;

`ifndef SYNTHESIS
    a_dw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.data_write_valid) |-> (r_res.data_write_value == '0))
        else $error("data word value without write");

    a_rx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.received_count == '0) |->
        (r_res.received_index == '0 && r_res.received_first == '0))
        else $error("receive fields set with no bytes delivered");

    a_rx_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.received_count != 2'd2) |-> (r_res.received_second == '0))
        else $error("second byte set without two bytes delivered");
`endif

endmodule
